>>> rtl/core/slc_pkg.sv
// Shared types and constants for the source line classifier.
package slc_pkg;

	localparam int COUNT_BITS_DEF          = 24;
	localparam int SHARE_FRACTION_BITS_DEF = 16;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SLASH,
		PH_COMMENT,
		PH_CODE
	} line_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_PUBLISH
	} ctrl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/core/slc_text_if.sv
// Input channel: one text byte per transaction.
interface slc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

>>> rtl/core/slc_report_if.sv
// Result channel: line counts and comment share per text.
interface slc_report_if #(
	parameter int COUNT_BITS          = slc_pkg::COUNT_BITS_DEF,
	parameter int SHARE_FRACTION_BITS = slc_pkg::SHARE_FRACTION_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [COUNT_BITS-1:0]        line_total;
	logic [COUNT_BITS-1:0]        code_total;
	logic [COUNT_BITS-1:0]        comment_total;
	logic [COUNT_BITS-1:0]        blank_total;
	logic [SHARE_FRACTION_BITS:0] comment_share;

	modport source (output valid, output line_total, output code_total, output comment_total,
		output blank_total, output comment_share, input ready);
	modport sink   (input valid, input line_total, input code_total, input comment_total,
		input blank_total, input comment_share, output ready);
endinterface

>>> rtl/core/slc_lexer.sv
// Per-byte line classifier with saturating line counters.
module slc_lexer #(
	parameter int COUNT_BITS = slc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            text_byte,
	input  logic                  final_byte,
	output logic [COUNT_BITS-1:0] lines_nx,
	output logic [COUNT_BITS-1:0] code_nx,
	output logic [COUNT_BITS-1:0] comment_nx,
	output logic [COUNT_BITS-1:0] blank_nx
);
	import slc_pkg::*;

	logic [COUNT_BITS-1:0] lines_q, code_q, comment_q, blank_q;
	line_phase_t           phase_q, phase_n, phase_after;
	logic                  inside_q, inside_n;
	logic                  star_q, star_n;
	logic                  close_line;

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] cnt);
		return (cnt == '1) ? cnt : cnt + 1'b1;
	endfunction

	always_comb begin
		phase_n  = phase_q;
		inside_n = inside_q;
		star_n   = star_q;
		if (inside_q) begin
			if (text_byte == CH_SLASH && star_q) begin
				inside_n = 1'b0;
				star_n   = 1'b0;
			end else begin
				star_n = (text_byte == CH_STAR);
			end
		end else if (text_byte != CH_NEWLINE) begin
			case (phase_q)
				PH_LEAD: begin
					if (text_byte == CH_SLASH)
						phase_n = PH_SLASH;
					else if (text_byte != CH_SPACE && text_byte != CH_TAB)
						phase_n = PH_CODE;
				end
				PH_SLASH: begin
					if (text_byte == CH_SLASH) begin
						phase_n = PH_COMMENT;
					end else if (text_byte == CH_STAR) begin
						phase_n  = PH_COMMENT;
						inside_n = 1'b1;
						star_n   = 1'b0;
					end else begin
						phase_n = PH_CODE;
					end
				end
				default: ;
			endcase
		end

		// newline ends a line; the last byte also ends its own line
		close_line  = (text_byte == CH_NEWLINE) || final_byte;
		lines_nx    = close_line ? bump(lines_q) : lines_q;
		blank_nx    = (close_line && phase_n == PH_LEAD) ? bump(blank_q) : blank_q;
		comment_nx  = (close_line && phase_n == PH_COMMENT) ? bump(comment_q) : comment_q;
		code_nx     = (close_line && (phase_n == PH_SLASH || phase_n == PH_CODE))
			? bump(code_q) : code_q;
		phase_after = close_line ? (inside_n ? PH_COMMENT : PH_LEAD) : phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q   <= '0;
			code_q    <= '0;
			comment_q <= '0;
			blank_q   <= '0;
			phase_q   <= PH_LEAD;
			inside_q  <= 1'b0;
			star_q    <= 1'b0;
		end else if (take) begin
			if (final_byte) begin
				lines_q   <= '0;
				code_q    <= '0;
				comment_q <= '0;
				blank_q   <= '0;
				phase_q   <= PH_LEAD;
				inside_q  <= 1'b0;
				star_q    <= 1'b0;
			end else begin
				lines_q   <= lines_nx;
				code_q    <= code_nx;
				comment_q <= comment_nx;
				blank_q   <= blank_nx;
				phase_q   <= phase_after;
				inside_q  <= inside_n;
				star_q    <= star_n;
			end
		end
	end

endmodule

>>> rtl/core/slc_divider.sv
// Restoring radix-2 divider: one quotient bit per cycle.
module slc_divider #(
	parameter int COUNT_BITS          = slc_pkg::COUNT_BITS_DEF,
	parameter int SHARE_FRACTION_BITS = slc_pkg::SHARE_FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [COUNT_BITS-1:0]        dividend,
	input  logic [COUNT_BITS-1:0]        divisor,
	output slc_pkg::div_status_t         status,
	output logic [SHARE_FRACTION_BITS:0] quotient
);
	import slc_pkg::*;

	localparam int NUM_BITS  = COUNT_BITS + SHARE_FRACTION_BITS;
	localparam int STEP_BITS = $clog2(NUM_BITS);

	logic [NUM_BITS-1:0]   num_q;    // dividend shifts out, quotient shifts in
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] divisor_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q, done_q;
	logic [COUNT_BITS:0]   rem_sh, diff;
	logic                  fits;

	assign rem_sh = {rem_q, num_q[NUM_BITS-1]};
	assign diff   = rem_sh - {1'b0, divisor_q};
	assign fits   = !diff[COUNT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q     <= {dividend, {SHARE_FRACTION_BITS{1'b0}}};
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], fits};
			rem_q <= fits ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = (divisor_q == '0) ? '0 : num_q[SHARE_FRACTION_BITS:0];

endmodule

>>> rtl/core/source_line_classifier_unit.sv
// Top level: source line classifier with counts and comment share.
//
//  channel  dir  payload                                           transaction
//  text     in   text_byte[7:0], final_byte                        one byte
//  report   out  line/code/comment/blank_total, comment_share      one per text
//
// Bytes are taken one per cycle while idle. The byte flagged final starts the
// divider, which works out the comment share in ST_DIVIDE; once it is done the
// sequencer moves the result into the output register in ST_PUBLISH and goes
// back to idle, and only then can the first byte of the next text be taken.
// Reset clears all counters and the line state. The output register holds a
// result until taken; the next text streams in meanwhile. If that result is
// still pending when the next share is ready, the sequencer holds in publish
// and the input stays not ready until the report side takes it.
module source_line_classifier_unit #(
	parameter int COUNT_BITS          = slc_pkg::COUNT_BITS_DEF,
	parameter int SHARE_FRACTION_BITS = slc_pkg::SHARE_FRACTION_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	slc_text_if.sink    text,
	slc_report_if.source report
);
	import slc_pkg::*;

	ctrl_state_t state_q, state_n;

	logic                         text_take;
	logic                         div_start;
	logic                         publish;
	div_status_t                  div_status;
	logic [SHARE_FRACTION_BITS:0] div_quotient;

	// counts including the line closed by the current byte
	logic [COUNT_BITS-1:0] lines_nx, code_nx, comment_nx, blank_nx;

	// snapshot of the finished text while the share is computed
	logic [COUNT_BITS-1:0] lines_snap_q, code_snap_q, comment_snap_q, blank_snap_q;

	// output register
	logic                         out_valid_q;
	logic [COUNT_BITS-1:0]        line_out_q, code_out_q, comment_out_q, blank_out_q;
	logic [SHARE_FRACTION_BITS:0] share_out_q;

	assign text.ready = (state_q == ST_IDLE);
	assign text_take  = text.valid && text.ready;
	assign div_start  = text_take && text.final_byte;

	slc_lexer #(
		.COUNT_BITS (COUNT_BITS)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (text_take),
		.text_byte  (text.text_byte),
		.final_byte (text.final_byte),
		.lines_nx   (lines_nx),
		.code_nx    (code_nx),
		.comment_nx (comment_nx),
		.blank_nx   (blank_nx)
	);

	slc_divider #(
		.COUNT_BITS          (COUNT_BITS),
		.SHARE_FRACTION_BITS (SHARE_FRACTION_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (comment_nx),
		.divisor  (lines_nx),
		.status   (div_status),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// sequencer: idle/stream -> divide -> publish into output register
	always_comb begin
		state_n = state_q;
		publish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (div_start)
					state_n = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_status.done)
					state_n = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (!out_valid_q || report.ready) begin
					publish = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			lines_snap_q   <= lines_nx;
			code_snap_q    <= code_nx;
			comment_snap_q <= comment_nx;
			blank_snap_q   <= blank_nx;
		end
		if (publish) begin
			line_out_q    <= lines_snap_q;
			code_out_q    <= code_snap_q;
			comment_out_q <= comment_snap_q;
			blank_out_q   <= blank_snap_q;
			share_out_q   <= div_quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (publish)
			out_valid_q <= 1'b1;
		else if (report.ready)
			out_valid_q <= 1'b0;
	end

	assign report.valid         = out_valid_q;
	assign report.line_total    = line_out_q;
	assign report.code_total    = code_out_q;
	assign report.comment_total = comment_out_q;
	assign report.blank_total   = blank_out_q;
	assign report.comment_share = share_out_q;

endmodule

>>> sim/slc_line_tally_checker.sv
// Checker for the source line classifier: predicts each report from the text stream and compares.
module slc_line_tally_checker
	import slc_pkg::*;
#(
	parameter int COUNT_BITS          = COUNT_BITS_DEF,
	parameter int SHARE_FRACTION_BITS = SHARE_FRACTION_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	slc_text_if   text,
	slc_report_if report,
	output int    fail_count,
	output int    pending,
	output int    texts_checked,
	output int    bytes_taken,
	output int    code_line_sum,
	output int    comment_line_sum,
	output int    blank_line_sum
);

	typedef struct packed {
		logic [COUNT_BITS-1:0]        lines;
		logic [COUNT_BITS-1:0]        code;
		logic [COUNT_BITS-1:0]        comment;
		logic [COUNT_BITS-1:0]        blank;
		logic [SHARE_FRACTION_BITS:0] share;
	} line_tally_t;

	line_tally_t           expected_tallies[$];

	// predicted line counts and line state of the current text
	logic [COUNT_BITS-1:0] n_lines, n_code, n_comment, n_blank;
	logic                  in_block;
	logic                  star_before;
	line_phase_t           phase;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void clear_text_state();
		n_lines     = '0;
		n_code      = '0;
		n_comment   = '0;
		n_blank     = '0;
		in_block    = 1'b0;
		star_before = 1'b0;
		phase       = PH_LEAD;
	endfunction

	function automatic void end_of_line();
		n_lines = sat_inc(n_lines);
		case (phase)
			PH_LEAD:    n_blank   = sat_inc(n_blank);
			PH_COMMENT: n_comment = sat_inc(n_comment);
			default:    n_code    = sat_inc(n_code);
		endcase
		phase = in_block ? PH_COMMENT : PH_LEAD;
	endfunction

	function automatic void classify_byte(input logic [7:0] c, input logic last);
		line_tally_t                                t;
		logic [COUNT_BITS+SHARE_FRACTION_BITS-1:0] scaled;
		logic [COUNT_BITS+SHARE_FRACTION_BITS-1:0] quotient;
		if (in_block) begin
			// opening star never pairs with a slash; newline breaks a star-slash pair
			if (c == CH_SLASH && star_before) begin
				in_block    = 1'b0;
				star_before = 1'b0;
			end else begin
				star_before = (c == CH_STAR);
			end
			if (c == CH_NEWLINE)
				end_of_line();
		end else if (c == CH_NEWLINE) begin
			end_of_line();
		end else begin
			case (phase)
				PH_LEAD: begin
					if (c == CH_SLASH)
						phase = PH_SLASH;
					else if (c != CH_SPACE && c != CH_TAB)
						phase = PH_CODE;
				end
				PH_SLASH: begin
					if (c == CH_SLASH) begin
						phase = PH_COMMENT;
					end else if (c == CH_STAR) begin
						phase       = PH_COMMENT;
						in_block    = 1'b1;
						star_before = 1'b0;
					end else begin
						phase = PH_CODE;
					end
				end
				default: ;
			endcase
		end
		if (last) begin
			if (c != CH_NEWLINE)
				end_of_line();
			t.lines   = n_lines;
			t.code    = n_code;
			t.comment = n_comment;
			t.blank   = n_blank;
			scaled    = {n_comment, {SHARE_FRACTION_BITS{1'b0}}};
			quotient  = (n_lines == '0) ? '0 : scaled / n_lines;
			t.share   = quotient[SHARE_FRACTION_BITS:0];
			expected_tallies.push_back(t);
			code_line_sum    += n_code;
			comment_line_sum += n_comment;
			blank_line_sum   += n_blank;
			clear_text_state();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[chk] %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got)
			report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	task automatic check_report();
		line_tally_t t;
		if (expected_tallies.size() == 0) begin
			report_mismatch("report transaction with no text pending");
		end else begin
			t = expected_tallies.pop_front();
			check_field("line_total", t.lines, report.line_total);
			check_field("code_total", t.code, report.code_total);
			check_field("comment_total", t.comment, report.comment_total);
			check_field("blank_total", t.blank, report.blank_total);
			check_field("comment_share", t.share, report.comment_share);
			texts_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_text_state();
			expected_tallies.delete();
			fail_count       = 0;
			pending          = 0;
			texts_checked    = 0;
			bytes_taken      = 0;
			code_line_sum    = 0;
			comment_line_sum = 0;
			blank_line_sum   = 0;
		end else begin
			if (report.valid && report.ready)
				check_report();
			if (text.valid && text.ready) begin
				bytes_taken++;
				classify_byte(text.text_byte, text.final_byte);
			end
			pending = expected_tallies.size();
		end
	end

endmodule

>>> sim/source_line_classifier_unit_tb.sv
// Testbench top for the source line classifier: text stimulus, report stalls and verdict.
module source_line_classifier_unit_tb;
	import slc_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BYTES = 1300;
	// divider plus output register plus margin
	localparam int DRAIN_CYCLES = COUNT_BITS_DEF + SHARE_FRACTION_BITS_DEF + 8;
	localparam int LIMIT_CYCLES = 600000;

	logic       clk = 1'b0;
	logic       arst_n;

	// idle percentages, switched between stimulus phases
	int         send_idle_pct;
	int         recv_stall_pct;
	int         bytes_sent;
	int         random_start;

	// checker outputs
	int         fail_count;
	int         pending;
	int         texts_checked;
	int         bytes_taken;
	int         code_line_sum;
	int         comment_line_sum;
	int         blank_line_sum;

	// bytes of the text being assembled; the last one goes out flagged final
	logic [7:0] text_buf[$];

	slc_text_if   text_ch();
	slc_report_if report_ch();

	source_line_classifier_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.report (report_ch)
	);

	slc_line_tally_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.text             (text_ch),
		.report           (report_ch),
		.fail_count       (fail_count),
		.pending          (pending),
		.texts_checked    (texts_checked),
		.bytes_taken      (bytes_taken),
		.code_line_sum    (code_line_sum),
		.comment_line_sum (comment_line_sum),
		.blank_line_sum   (blank_line_sum)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout after %0d cycles, %0d reports still pending", LIMIT_CYCLES, pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Report side back-pressure: ready is re-rolled every cycle, so stalls land
	// on every phase of the divide and publish sequence.
	initial begin
		report_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			report_ch.ready <= (arst_n === 1'b1) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Text builders. Each put_* appends bytes to text_buf.
	// ---------------------------------------------------------------------
	function automatic logic [7:0] blank_char();
		return $urandom_range(1) ? CH_SPACE : CH_TAB;
	endfunction

	// Anything but a newline, with comment marks and whitespace favored so that
	// star/slash pairs show up often inside block comments.
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		case ($urandom_range(5))
			0:       c = CH_STAR;
			1:       c = CH_SLASH;
			2:       c = blank_char();
			default: c = 8'($urandom_range(255));
		endcase
		if (c == CH_NEWLINE)
			c = "x";
		return c;
	endfunction

	// First non-blank character of a code line: any byte, zero and CR included,
	// other than whitespace, slash or newline.
	function automatic logic [7:0] code_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == CH_SPACE || c == CH_TAB || c == CH_SLASH || c == CH_NEWLINE)
			c = "q";
		return c;
	endfunction

	function automatic void put_blanks();
		repeat ($urandom_range(2))
			text_buf.push_back(blank_char());
	endfunction

	function automatic void put_body(input int max_len);
		repeat ($urandom_range(max_len))
			text_buf.push_back(body_char());
	endfunction

	function automatic void put_string(input string s);
		foreach (s[i])
			text_buf.push_back(s[i]);
	endfunction

	// One line of C-ish text. Mostly well-formed lines with random content; a
	// share of them leave a block comment open or are raw noise.
	function automatic void put_line();
		int         kind;
		logic [7:0] c;
		kind = $urandom_range(99);
		put_blanks();
		if (kind < 12) begin
			// whitespace-only line
		end else if (kind < 35) begin
			text_buf.push_back(code_char());
			put_body(8);
		end else if (kind < 50) begin
			// line comment
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(CH_SLASH);
			put_body(6);
		end else if (kind < 68) begin
			// block comment over up to four lines, some of them blank
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(CH_STAR);
			put_body(4);
			repeat ($urandom_range(3)) begin
				text_buf.push_back(CH_NEWLINE);
				put_blanks();
				put_body(4);
			end
			text_buf.push_back(CH_STAR);
			text_buf.push_back(CH_SLASH);
			put_body(4);
		end else if (kind < 76) begin
			// lone slash, either alone or followed by something else
			text_buf.push_back(CH_SLASH);
			if ($urandom_range(1)) begin
				c = body_char();
				if (c == CH_SLASH || c == CH_STAR)
					c = "y";
				text_buf.push_back(c);
				put_body(4);
			end
		end else if (kind < 84) begin
			// comment mark trailing code: must not open anything
			text_buf.push_back(code_char());
			text_buf.push_back(CH_SLASH);
			text_buf.push_back($urandom_range(1) ? CH_STAR : CH_SLASH);
			put_body(4);
		end else if (kind < 92) begin
			// block left open, sometimes with a star and slash split by a newline
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(CH_STAR);
			put_body(3);
			if ($urandom_range(1)) begin
				text_buf.push_back(CH_STAR);
				text_buf.push_back(CH_NEWLINE);
				text_buf.push_back(CH_SLASH);
			end
		end else begin
			// raw noise, newlines possible
			repeat ($urandom_range(1, 6))
				text_buf.push_back(8'($urandom_range(255)));
		end
		text_buf.push_back(CH_NEWLINE);
	endfunction

	// ---------------------------------------------------------------------
	// Text channel driver
	// ---------------------------------------------------------------------
	// Called right after a rising edge. Valid only drops when an idle cycle is
	// rolled, so back-to-back transactions keep it high with a single update.
	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= b;
		text_ch.final_byte <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			push_byte(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	// ---------------------------------------------------------------------
	// Main stimulus
	// ---------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		text_ch.valid      = 1'b0;
		text_ch.text_byte  = '0;
		text_ch.final_byte = 1'b0;
		send_idle_pct      = 32;
		recv_stall_pct     = 85;
		bytes_sent         = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed texts.
		// Single all-ones byte flagged final: one code line, no newline.
		text_buf.push_back(8'hFF);
		send_text();
		// Whitespace-only line, slash then other char, line comment, block opened
		// and carried over a blank line, star and slash split by a newline, a later
		// star and slash closing the block, text after the close ignored, and a lone
		// slash as the very last byte.
		put_string(" \t\n/x\n//\n/*\n \n*\n/*/ /*\n/");
		send_text();
		// Zero byte is ordinary code; the trailing newline adds no extra line.
		text_buf.push_back(8'h00);
		text_buf.push_back(CH_NEWLINE);
		send_text();

		// Random texts, in three idling mixes.
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (bytes_sent - random_start >= 2 * RANDOM_BYTES / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end else if (bytes_sent - random_start >= RANDOM_BYTES / 3) begin
				send_idle_pct  = 85;
				recv_stall_pct = 32;
			end
			repeat ($urandom_range(1, 5))
				put_line();
			// about a third of the texts end without a closing newline
			if ($urandom_range(2) == 0 && text_buf.size() > 1)
				void'(text_buf.pop_back());
			send_text();
		end
		text_ch.valid <= 1'b0;

		// Let the checker see the last transaction, then drain the reports.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d text bytes in %0d texts, under both stall mixes and none",
			bytes_taken, texts_checked);
		$display("lines predicted: %0d code, %0d comment, %0d blank",
			code_line_sum, comment_line_sum, blank_line_sum);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d reports missing", fail_count, pending);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
